/* hw/rtl/rcpca_pkg.sv */
package rcpca_pkg;

   // Input word: one capture edge or one arming check tick
   typedef struct packed {
      logic        func;
      logic [1:0]  channel;
      logic [31:0] timestamp;
   } req_word_type;

   // Result word: one per input word
   typedef struct packed {
      logic        armed;
      logic        pulse_done;
      logic [1:0]  pulse_channel;
      logic [31:0] pulse_width;
   } rsp_word_type;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_TICKS_PER_UNIT  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COUNT_DOWN_MASK = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STICK_HIGH      = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STICK_LOW       = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HOLD_TICKS      = 3'd4;

   localparam logic [15:0] TICKS_PER_UNIT_RESET  = 16'd50;
   localparam logic [3:0]  COUNT_DOWN_MASK_RESET = 4'd3;
   localparam logic [15:0] STICK_HIGH_RESET      = 16'd1800;
   localparam logic [15:0] STICK_LOW_RESET       = 16'd1200;
   localparam logic [15:0] HOLD_TICKS_RESET      = 16'd30;

   localparam logic FUNC_CAPTURE = 1'b0;
   localparam logic FUNC_TICK    = 1'b1;

   // Controller -> datapath
   typedef struct packed {
      logic load;        // latch the accepted word
      logic start_div;   // launch the divider on the current pulse
      logic commit_now;  // finish a tick, rising edge or ignored edge
      logic commit_div;  // finish a falling edge with the quotient
   } cmd_type;

   // Datapath -> controller
   typedef struct packed {
      logic is_fall;     // latched word closes a pulse
      logic div_done;    // divider idle, quotient valid
      logic out_free;    // result register can take a word this cycle
   } status_type;

endpackage

/* hw/rtl/rcpca_div.sv */
module rcpca_div #(
   parameter int STAMP_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [STAMP_BITS-1:0] dividend,
   input  logic [15:0]           divisor,
   output logic                  busy,
   output logic [STAMP_BITS-1:0] quotient
);
   localparam int CNT_BITS = $clog2(STAMP_BITS);
   localparam logic [CNT_BITS-1:0] STEP_LAST = CNT_BITS'(STAMP_BITS - 1);

   logic                  busy_ff, busy_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [STAMP_BITS-1:0] quo_ff, quo_in;
   logic [15:0]           rem_ff, rem_in;
   logic [15:0]           dvs_ff, dvs_in;
   logic [16:0]           rem_shift;
   logic [16:0]           rem_sub;

   // restoring divide, one quotient bit per cycle
   always_comb begin
      rem_shift = {rem_ff, quo_ff[STAMP_BITS-1]};
      rem_sub   = rem_shift - {1'b0, dvs_ff};
      busy_in   = busy_ff;
      cnt_in    = cnt_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      dvs_in    = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = (divisor == 16'd0) ? 16'd1 : divisor;
      end else if (busy_ff) begin
         if (rem_shift >= {1'b0, dvs_ff}) begin
            rem_in = rem_sub[15:0];
            quo_in = {quo_ff[STAMP_BITS-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[15:0];
            quo_in = {quo_ff[STAMP_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == STEP_LAST) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;
endmodule

/* hw/rtl/rcpca_dp.sv */
module rcpca_dp #(
   parameter int CHANNELS   = 4,
   parameter int STAMP_BITS = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  rcpca_pkg::req_word_type                req_data,
   output rcpca_pkg::rsp_word_type                rsp_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   input  logic                                   csr_write,
   input  logic [rcpca_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [rcpca_pkg::CSR_DATA_BITS-1:0]    csr_data,
   input  rcpca_pkg::cmd_type                     cmd,
   output rcpca_pkg::status_type                  status
);
   import rcpca_pkg::*;

   localparam int CH_BITS  = $clog2(CHANNELS);
   localparam int YAW_CH   = 0;
   localparam int THR_CH   = 1;
   localparam int ROLL_CH  = 2;
   localparam int PITCH_CH = 3;

   function automatic logic [15:0] sat_inc(input logic [15:0] h);
      return (h == 16'hFFFF) ? h : h + 16'd1;
   endfunction

   // configuration registers
   logic [15:0] tpu_ff, high_ff, low_ff, hold_ff;
   logic [3:0]  mask_ff;

   // per-channel capture state
   logic [CHANNELS-1:0]   await_ff, await_in;
   logic [STAMP_BITS-1:0] rise_ff  [CHANNELS];
   logic [31:0]           width_ff [CHANNELS];

   logic        armed_ff, armed_in;
   logic [15:0] disarm_ff, disarm_in;
   logic [15:0] arm_ff, arm_in;

   req_word_type item_ff;
   rsp_word_type rsp_ff, rsp_in;
   logic         rsp_valid_ff, rsp_valid_in;

   logic [CH_BITS-1:0]    chan_idx;
   logic                  chan_ok;
   logic [STAMP_BITS-1:0] stamp;
   logic [STAMP_BITS-1:0] diff;
   logic                  div_busy;
   logic [STAMP_BITS-1:0] quotient;
   logic                  out_free;

   logic        dis_gest, dis_fire, armed_mid, arm_gest, arm_fire;
   logic [15:0] dis_cnt, arm_cnt;

   assign chan_idx = CH_BITS'(item_ff.channel);
   assign chan_ok  = (32'(item_ff.channel) < 32'(CHANNELS));
   assign stamp    = item_ff.timestamp[STAMP_BITS-1:0];
   assign diff     = mask_ff[item_ff.channel] ? rise_ff[chan_idx] - stamp
                                              : stamp - rise_ff[chan_idx];
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign status.is_fall  = (item_ff.func == FUNC_CAPTURE) && chan_ok && await_ff[chan_idx];
   assign status.div_done = !div_busy;
   assign status.out_free = out_free;

   rcpca_div #(
      .STAMP_BITS (STAMP_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.start_div),
      .dividend (diff),
      .divisor  (tpu_ff),
      .busy     (div_busy),
      .quotient (quotient)
   );

   // arming check: disarm step first, then arm step on what it leaves
   always_comb begin
      dis_gest  = armed_ff
                  && (width_ff[ROLL_CH]  >= 32'(high_ff))
                  && (width_ff[PITCH_CH] <= 32'(low_ff))
                  && (width_ff[THR_CH]   <= 32'(low_ff))
                  && (width_ff[YAW_CH]   <= 32'(low_ff));
      dis_cnt   = dis_gest ? sat_inc(disarm_ff) : 16'd0;
      dis_fire  = armed_ff && (dis_cnt > hold_ff);
      armed_mid = dis_fire ? 1'b0 : armed_ff;
      arm_gest  = !armed_mid
                  && (width_ff[YAW_CH]   >= 32'(high_ff))
                  && (width_ff[PITCH_CH] <= 32'(low_ff))
                  && (width_ff[THR_CH]   <= 32'(low_ff))
                  && (width_ff[ROLL_CH]  <= 32'(low_ff));
      arm_cnt   = arm_gest ? sat_inc(arm_ff) : 16'd0;
      arm_fire  = arm_gest && (arm_cnt >= hold_ff);
   end

   always_comb begin
      armed_in     = armed_ff;
      disarm_in    = disarm_ff;
      arm_in       = arm_ff;
      await_in     = await_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.commit_now) begin
         rsp_valid_in         = 1'b1;
         rsp_in.armed         = armed_ff;
         rsp_in.pulse_done    = 1'b0;
         rsp_in.pulse_channel = 2'd0;
         rsp_in.pulse_width   = 32'd0;
         if (item_ff.func == FUNC_TICK) begin
            armed_in     = arm_fire ? 1'b1 : armed_mid;
            disarm_in    = dis_fire ? 16'd0 : dis_cnt;
            arm_in       = arm_fire ? 16'd0 : arm_cnt;
            rsp_in.armed = armed_in;
         end else if (chan_ok) begin
            await_in[chan_idx] = 1'b1;
         end
      end else if (cmd.commit_div) begin
         rsp_valid_in         = 1'b1;
         await_in[chan_idx]   = 1'b0;
         rsp_in.armed         = armed_ff;
         rsp_in.pulse_done    = 1'b1;
         rsp_in.pulse_channel = item_ff.channel;
         rsp_in.pulse_width   = 32'(quotient);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tpu_ff       <= TICKS_PER_UNIT_RESET;
         mask_ff      <= COUNT_DOWN_MASK_RESET;
         high_ff      <= STICK_HIGH_RESET;
         low_ff       <= STICK_LOW_RESET;
         hold_ff      <= HOLD_TICKS_RESET;
         await_ff     <= '0;
         armed_ff     <= 1'b0;
         disarm_ff    <= '0;
         arm_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < CHANNELS; c++) begin
            width_ff[c] <= '0;
         end
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_TICKS_PER_UNIT:  tpu_ff  <= csr_data;
               CSR_COUNT_DOWN_MASK: mask_ff <= csr_data[3:0];
               CSR_STICK_HIGH:      high_ff <= csr_data;
               CSR_STICK_LOW:       low_ff  <= csr_data;
               CSR_HOLD_TICKS:      hold_ff <= csr_data;
               default: ;
            endcase
         end
         await_ff     <= await_in;
         armed_ff     <= armed_in;
         disarm_ff    <= disarm_in;
         arm_ff       <= arm_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.commit_div) begin
            width_ff[chan_idx] <= 32'(quotient);
         end
      end
      if (cmd.load) begin
         item_ff <= req_data;
      end
      if (cmd.commit_now && item_ff.func == FUNC_CAPTURE && chan_ok) begin
         rise_ff[chan_idx] <= stamp;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_data  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;
endmodule

/* hw/rtl/rcpca_ctrl.sv */
module rcpca_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  rcpca_pkg::status_type status,
   output rcpca_pkg::cmd_type    cmd
);
   import rcpca_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;

   logic [1:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (status.is_fall) begin
               cmd.start_div = 1'b1;
               state_in      = ST_DIV;
            end else if (status.out_free) begin
               cmd.commit_now = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_DIV: begin
            if (status.div_done && status.out_free) begin
               cmd.commit_div = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

/* hw/rtl/rc_pulse_capture_arming.sv */
// RC pulse capture with stick arming. Each req word is either a capture edge
// (func 0: channel and latched timer stamp) or an arming check tick (func 1),
// and each gives exactly one rsp word. A channel alternates rising/falling
// edges; the falling edge reports the width, (fall - rise) for up-counting
// channels or (rise - fall) for down-counting ones, modulo 2^STAMP_BITS and
// divided by ticks_per_unit (0 acts as 1). A tick runs the disarm and arm
// hold counters on the stored yaw/throttle/roll/pitch widths (channels 0-3).
// Sequencing: the block works on one word at a time. A tick or rising edge is
// committed from the execute state into the result register once that
// register is free; a falling edge first launches the restoring divider,
// which produces one quotient bit per cycle, and the quotient is then moved
// into the result register once the divider is done and the register is
// free. The rsp word sits in an output register, so the next req word is
// taken while it waits.
// Configuration writes are always accepted (csr_ready tied high) and must
// only come while the block is idle.
module rc_pulse_capture_arming #(
   parameter int CHANNELS   = 4,
   parameter int STAMP_BITS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  rcpca_pkg::req_word_type              req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output rcpca_pkg::rsp_word_type              rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [rcpca_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [rcpca_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import rcpca_pkg::*;

   cmd_type    cmd;
   status_type status;

   // registers take a write in any cycle
   assign csr_ready = 1'b1;

   // sequence each word: accept, execute, divide when it closes a pulse
   rcpca_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // channel state, divider, arming counters and the result register
   rcpca_dp #(
      .CHANNELS   (CHANNELS),
      .STAMP_BITS (STAMP_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status)
   );
endmodule

/* hw/rtl/rcpca_chk.sv */
module rcpca_chk (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input rcpca_pkg::rsp_word_type              rsp_data
);
   // words accepted whose result is not yet taken
   logic [1:0] pending_ff, pending_in;

   always_comb begin
      pending_in = pending_ff;
      if ((req_valid && req_ready) && !(rsp_valid && rsp_ready)) begin
         pending_in = pending_ff + 2'd1;
      end else if (!(req_valid && req_ready) && (rsp_valid && rsp_ready)) begin
         pending_in = pending_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp word changed while stalled");

   a_no_orphan_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 2'd0)
      else $error("rsp word without an accepted req word");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> pending_ff <= 2'd1)
      else $error("more than two words in flight");

   a_idle_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.pulse_done
         |-> rsp_data.pulse_channel == 2'd0 && rsp_data.pulse_width == 32'd0)
      else $error("pulse fields set without a completed pulse");
endmodule

bind rc_pulse_capture_arming rcpca_chk u_rcpca_chk (.*);
